FILE: sv/cpu_bus_decoder_with_pad_ports_unit_macros.svh
// ----------------------------------------------------------------------------
// cpu bus decoder assertion macros
// shared property forms for the checker files
// ----------------------------------------------------------------------------
`ifndef CPU_BUS_DECODER_WITH_PAD_PORTS_UNIT_MACROS_SVH
`define CPU_BUS_DECODER_WITH_PAD_PORTS_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define CBD_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("cbd assertion failed");

// next-cycle implication, disabled during reset
`define CBD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("cbd assertion failed");

`endif

FILE: sv/cbd_pkg.sv
// ----------------------------------------------------------------------------
// cbd_pkg
// constants, target codes and decode struct of the cpu bus decoder
// ----------------------------------------------------------------------------
package cbd_pkg;

    // work ram index width, ram holds 2^RAM_ADDR_BITS bytes
    localparam int RAM_ADDR_BITS = 11;
    localparam int RAM_DEPTH     = 1 << RAM_ADDR_BITS;

    // target codes
    localparam logic [2:0] TGT_RAM  = 3'd0;
    localparam logic [2:0] TGT_PAD  = 3'd1;
    localparam logic [2:0] TGT_PPU  = 3'd2;
    localparam logic [2:0] TGT_APU  = 3'd3;
    localparam logic [2:0] TGT_CRAM = 3'd4;
    localparam logic [2:0] TGT_CPRG = 3'd5;
    localparam logic [2:0] TGT_NONE = 3'd6;

    // access kinds
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // io register addresses
    localparam logic [15:0] ADDR_DMA  = 16'h4014;
    localparam logic [15:0] ADDR_SND  = 16'h4015;
    localparam logic [15:0] ADDR_PAD1 = 16'h4016;
    localparam logic [15:0] ADDR_PAD2 = 16'h4017;

    // region boundaries
    localparam logic [15:0] ADDR_PPU_BASE  = 16'h2000;
    localparam logic [15:0] ADDR_IO_BASE   = 16'h4000;
    localparam logic [15:0] ADDR_IO_END    = 16'h4020;
    localparam logic [15:0] ADDR_CRAM_BASE = 16'h6000;
    localparam logic [15:0] ADDR_CPRG_BASE = 16'h8000;

    // pad read open-bus bits
    localparam logic [7:0] PAD_OPEN_BUS = 8'h40;

    // sprite dma stall lengths
    localparam logic [9:0] DMA_STALL_ODD  = 10'd513;
    localparam logic [9:0] DMA_STALL_EVEN = 10'd514;

    // stream widths
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 32;

    // per-access decode
    typedef struct packed {
        logic [2:0] target;
        logic       ram_access;
        logic       pad_one_rd;
        logic       pad_two_rd;
        logic       strobe_wr;
        logic       dma;
    } decode_t;

endpackage

FILE: sv/cbd_decode.sv
// ----------------------------------------------------------------------------
// cbd_decode
// address map decode of one cpu bus access
// ----------------------------------------------------------------------------
module cbd_decode (
    input  logic            op,
    input  logic [15:0]     address,
    output cbd_pkg::decode_t dec
);

    // address map
    always_comb
    begin
        dec = '0;
        dec.target = cbd_pkg::TGT_NONE;
        if (address < cbd_pkg::ADDR_PPU_BASE)
        begin
            dec.target     = cbd_pkg::TGT_RAM;
            dec.ram_access = 1'b1;
        end
        else if (address < cbd_pkg::ADDR_IO_BASE)
        begin
            dec.target = cbd_pkg::TGT_PPU;
        end
        else if (address < cbd_pkg::ADDR_IO_END)
        begin
            if (op == cbd_pkg::OP_READ)
            begin
                // reads: only status and the two pad ports answer
                if (address == cbd_pkg::ADDR_SND)
                begin
                    dec.target = cbd_pkg::TGT_APU;
                end
                else if (address == cbd_pkg::ADDR_PAD1)
                begin
                    dec.target     = cbd_pkg::TGT_PAD;
                    dec.pad_one_rd = 1'b1;
                end
                else if (address == cbd_pkg::ADDR_PAD2)
                begin
                    dec.target     = cbd_pkg::TGT_PAD;
                    dec.pad_two_rd = 1'b1;
                end
            end
            else if (address == cbd_pkg::ADDR_DMA)
            begin
                dec.target = cbd_pkg::TGT_PPU;
                dec.dma    = 1'b1;
            end
            else if (address == cbd_pkg::ADDR_PAD1)
            begin
                dec.target    = cbd_pkg::TGT_PAD;
                dec.strobe_wr = 1'b1;
            end
            else if (address <= cbd_pkg::ADDR_PAD2)
            begin
                dec.target = cbd_pkg::TGT_APU;
            end
        end
        else if (address >= cbd_pkg::ADDR_CPRG_BASE)
        begin
            dec.target = cbd_pkg::TGT_CPRG;
        end
        else if (address >= cbd_pkg::ADDR_CRAM_BASE)
        begin
            dec.target = cbd_pkg::TGT_CRAM;
        end
    end

endmodule

FILE: sv/cpu_bus_decoder_with_pad_ports_unit.sv
// path: an accepted word is held in the work stage, then registered into m_tvalid
// throughput: one word per cycle when m_tready does not stall; the work ram read is
//   issued on accept and the previous word's write-back is forwarded to it on an index match
// reset: a clearing pass writes zero to all 2048 ram bytes, one per cycle,
//   with s_tready low; strobe and both pad shift registers reset to zero
// ----------------------------------------------------------------------------
// cpu_bus_decoder_with_pad_ports_unit
// cpu memory map with mirrored work ram, pad serial ports and dma report
// ----------------------------------------------------------------------------
module cpu_bus_decoder_with_pad_ports_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // address[15:0], write_data[23:16], pad_one_buttons[31:24],
    // pad_two_buttons[39:32], odd_cycle[40], zero fill
    input  logic [cbd_pkg::S_TDATA_W-1:0] s_tdata,
    // op[0]
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // read_data[7:0], dma_start[8], dma_page[16:9], dma_stall[26:17], zero fill
    output logic [cbd_pkg::M_TDATA_W-1:0] m_tdata,
    // target[2:0]
    output logic [2:0]  m_tuser
);

    localparam int AW = cbd_pkg::RAM_ADDR_BITS;

    // clear pass
    logic          clr_busy_reg;
    logic [AW-1:0] clr_addr_reg;

    // work stage
    logic          a_valid_reg;
    logic          a_op_reg;
    logic [15:0]   a_addr_reg;
    logic [7:0]    a_wdata_reg;
    logic [7:0]    a_pad1_reg;
    logic [7:0]    a_pad2_reg;
    logic          a_odd_reg;

    // ram and forwarding
    logic [7:0]    ram_mem [cbd_pkg::RAM_DEPTH];
    logic [7:0]    ram_rdata_reg;
    logic          fwd_hit_reg;
    logic [7:0]    fwd_data_reg;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic [AW-1:0] s_index;
    logic [7:0]    ram_value;

    // pad state
    logic          strobe_reg;
    logic          strobe_next;
    logic [7:0]    pad1_shift_reg;
    logic [7:0]    pad1_shift_next;
    logic [7:0]    pad2_shift_reg;
    logic [7:0]    pad2_shift_next;

    // output register
    logic          m_valid_reg;
    logic [cbd_pkg::M_TDATA_W-1:0] m_data_reg;
    logic [cbd_pkg::M_TDATA_W-1:0] m_data_next;
    logic [2:0]    m_user_reg;

    logic          a_advance;
    logic          s_accept;
    logic [7:0]    rd_next;
    logic [9:0]    stall_next;
    logic          item_write;
    cbd_pkg::decode_t dec;

    // handshake
    assign a_advance = a_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready  = !clr_busy_reg && (!a_valid_reg || a_advance);
    assign s_accept  = s_tvalid && s_tready;
    assign s_index   = s_tdata[AW-1:0];

    // decode of the word in the work stage
    cbd_decode u_decode (
        .op      (a_op_reg),
        .address (a_addr_reg),
        .dec     (dec)
    );

    assign item_write = a_op_reg == cbd_pkg::OP_WRITE;

    // ram write port: clear pass or write-back of the work stage
    always_comb
    begin
        if (clr_busy_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_reg;
            ram_wdata = 8'h00;
        end
        else
        begin
            ram_we    = a_advance && dec.ram_access && item_write;
            ram_waddr = a_addr_reg[AW-1:0];
            ram_wdata = a_wdata_reg;
        end
    end

    // work ram, read-first
    always_ff @(posedge clk)
    begin
        if (ram_we)
        begin
            ram_mem[ram_waddr] <= ram_wdata;
        end
        if (s_accept)
        begin
            ram_rdata_reg <= ram_mem[s_index];
            fwd_hit_reg   <= ram_we && (ram_waddr == s_index);
            fwd_data_reg  <= ram_wdata;
        end
    end

    assign ram_value = fwd_hit_reg ? fwd_data_reg : ram_rdata_reg;

    // clear pass sequencing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clr_busy_reg)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == {AW{1'b1}})
            begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    // work stage capture
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (s_accept)
        begin
            a_valid_reg <= 1'b1;
        end
        else if (a_advance)
        begin
            a_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            a_op_reg    <= s_tuser;
            a_addr_reg  <= s_tdata[15:0];
            a_wdata_reg <= s_tdata[23:16];
            a_pad1_reg  <= s_tdata[31:24];
            a_pad2_reg  <= s_tdata[39:32];
            a_odd_reg   <= s_tdata[40];
        end
    end

    // pad ports and read data
    always_comb
    begin
        strobe_next     = strobe_reg;
        pad1_shift_next = pad1_shift_reg;
        pad2_shift_next = pad2_shift_reg;
        rd_next         = 8'h00;
        if (dec.ram_access && !item_write)
        begin
            rd_next = ram_value;
        end
        else if (dec.pad_one_rd)
        begin
            if (strobe_reg)
            begin
                rd_next = {7'b0, a_pad1_reg[0]} | cbd_pkg::PAD_OPEN_BUS;
            end
            else
            begin
                rd_next         = {7'b0, pad1_shift_reg[0]} | cbd_pkg::PAD_OPEN_BUS;
                pad1_shift_next = {1'b1, pad1_shift_reg[7:1]};
            end
        end
        else if (dec.pad_two_rd)
        begin
            if (strobe_reg)
            begin
                rd_next = {7'b0, a_pad2_reg[0]} | cbd_pkg::PAD_OPEN_BUS;
            end
            else
            begin
                rd_next         = {7'b0, pad2_shift_reg[0]} | cbd_pkg::PAD_OPEN_BUS;
                pad2_shift_next = {1'b1, pad2_shift_reg[7:1]};
            end
        end
        else if (dec.strobe_wr)
        begin
            // reload while strobe is or becomes high
            if (a_wdata_reg[0] || strobe_reg)
            begin
                pad1_shift_next = a_pad1_reg;
                pad2_shift_next = a_pad2_reg;
            end
            strobe_next = a_wdata_reg[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg     <= 1'b0;
            pad1_shift_reg <= 8'h00;
            pad2_shift_reg <= 8'h00;
        end
        else if (a_advance)
        begin
            strobe_reg     <= strobe_next;
            pad1_shift_reg <= pad1_shift_next;
            pad2_shift_reg <= pad2_shift_next;
        end
    end

    // result word
    assign stall_next = a_odd_reg ? cbd_pkg::DMA_STALL_ODD : cbd_pkg::DMA_STALL_EVEN;

    always_comb
    begin
        m_data_next        = '0;
        m_data_next[7:0]   = rd_next;
        m_data_next[8]     = dec.dma;
        m_data_next[16:9]  = dec.dma ? a_wdata_reg : 8'h00;
        m_data_next[26:17] = dec.dma ? stall_next : 10'd0;
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (a_advance)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_advance)
        begin
            m_data_reg <= m_data_next;
            m_user_reg <= dec.target;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

FILE: sv/cbd_checker.sv
// ----------------------------------------------------------------------------
// cbd_checker
// port-level checks of the cpu bus decoder access and result streams
// ----------------------------------------------------------------------------
`include "cpu_bus_decoder_with_pad_ports_unit_macros.svh"

module cbd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [cbd_pkg::S_TDATA_W-1:0] s_tdata,
    input logic        s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [cbd_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [2:0]  m_tuser
);

    logic [cbd_pkg::S_TDATA_W:0]   s_word;
    logic [cbd_pkg::M_TDATA_W+2:0] m_word;
    logic [9:0]                    res_stall;
    logic                          res_dma;
    logic                          dma_ok;
    logic                          is_pad;
    logic                          pad_ok;

    // whole words and result fields
    assign s_word    = {s_tuser, s_tdata};
    assign m_word    = {m_tuser, m_tdata};
    assign res_stall = m_tdata[26:17];
    assign res_dma   = m_tdata[8];
    assign dma_ok    = (m_tuser == cbd_pkg::TGT_PPU) &&
                       ((res_stall == cbd_pkg::DMA_STALL_ODD) ||
                        (res_stall == cbd_pkg::DMA_STALL_EVEN));
    assign is_pad    = m_tuser == cbd_pkg::TGT_PAD;
    assign pad_ok    = (m_tdata[7:1] == 7'h20) || (m_tdata[7:0] == 8'h00);

    // a waiting access word holds
    `CBD_ASSERT_NEXT(a_in_hold, clk, rst_n, s_tvalid && !s_tready, s_tvalid && $stable(s_word))

    // a stalled result word holds
    `CBD_ASSERT_NEXT(a_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_word))

    // a dma start always names the ppu and a legal stall
    `CBD_ASSERT_NOW(a_dma_ppu, clk, rst_n, m_tvalid && res_dma, dma_ok)

    // without a dma start page and stall stay zero
    `CBD_ASSERT_NOW(a_no_dma, clk, rst_n, m_tvalid && !res_dma, m_tdata[26:9] == 18'd0)

    // pad port words carry only the open-bus bit and one serial bit
    `CBD_ASSERT_NOW(a_pad_data, clk, rst_n, m_tvalid && is_pad, pad_ok)

endmodule

bind cpu_bus_decoder_with_pad_ports_unit cbd_checker u_cbd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
